/* design/skt_pkg.sv */
// Shared types and constants for the sorted key table.
// Holds the beat structs, action and status codes, and table sizing.
// No dependencies.
package skt_pkg;

    // Table sizing.
    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 64;
    localparam int PAY_W   = 32;
    localparam int ENTRY_W = KEY_W + PAY_W;
    localparam int POS_W   = 6;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 3;
    localparam int OCNT_W  = 7;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_DESCENDING = 1'b0;
    localparam logic REG_ALLOW_DUP  = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_FIND   = 3'd2,
        ACT_GET    = 3'd3,
        ACT_DELETE = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [POS_W-1:0] position;
    } in_beat_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  key_out;
        logic [PAY_W-1:0]  payload_out;
        logic [OCNT_W-1:0] count;
    } out_beat_t;

    // Commands from the sequencer to the search unit.
    typedef struct packed {
        logic start;
        logic compare;
    } search_cmd_t;

    // Search unit status back to the sequencer.
    typedef struct packed {
        logic             open;
        logic             hit;
        logic [IDX_W-1:0] mid;
        logic [CNT_W-1:0] where;
    } search_stat_t;

endpackage

/* design/skt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; width and depth are parameters.
module skt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, and read port returning the old contents on a collision.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/skt_search_unit.sv */
// Binary search unit: holds the low/high bounds and the shared key comparator.
// Depends on skt_pkg for sizing and the command/status structs.
module skt_search_unit
    import skt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  search_cmd_t      cmd,
    input  logic [KEY_W-1:0] key,
    input  logic             descending,
    input  logic [CNT_W-1:0] count,
    input  logic [KEY_W-1:0] probe_key,
    output search_stat_t     stat
);

    localparam int SUM_W = CNT_W + 1;

    // The upper bound is kept as high + 1 so that it never goes negative.
    logic [CNT_W-1:0] low_reg, low_next;
    logic [CNT_W-1:0] hi1_reg, hi1_next;
    logic             hit_reg, hit_next;
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] mid;
    logic             key_eq;
    logic             go_left;

    // Midpoint of the open interval, rounded down.
    always_comb begin
        sum = SUM_W'(low_reg) + SUM_W'(hi1_reg) - SUM_W'(1);
        mid = sum[IDX_W:1];
    end

    // Shared comparator, with the sort direction folded in.
    assign key_eq  = (key == probe_key);
    assign go_left = (key < probe_key) ^ descending;

    // Bound update.
    always_comb begin
        low_next = low_reg;
        hi1_next = hi1_reg;
        hit_next = hit_reg;
        if (cmd.start) begin
            low_next = '0;
            hi1_next = count;
            hit_next = 1'b0;
        end else if (cmd.compare) begin
            if (key_eq) begin
                hit_next = 1'b1;
            end else if (go_left) begin
                hi1_next = CNT_W'(mid);
            end else begin
                low_next = CNT_W'(mid) + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg <= '0;
            hi1_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            low_reg <= low_next;
            hi1_reg <= hi1_next;
            hit_reg <= hit_next;
        end
    end

    // On a hit the bounds hold still, so the midpoint is the hit index.
    always_comb begin
        stat.open  = !hit_reg && (low_reg < hi1_reg);
        stat.hit   = hit_reg;
        stat.mid   = mid;
        stat.where = hit_reg ? CNT_W'(mid) : low_reg;
    end

endmodule

/* design/sorted_key_table_core.sv */
// Top level of the sorted key table: sequencer, configuration registers and
// output register. Depends on skt_pkg, skt_ram and skt_search_unit.
//
// Usage:
//   The input channel (s_valid/s_ready/s_data) takes one action beat at a time:
//   add, remove by key, find by key, get by index or delete by index. Each beat
//   gives exactly one result beat on m_valid/m_ready/m_data with a status, the
//   key and payload read, and the entry count after the action.
//   Entries live in one RAM. A key lookup is a binary search of P probes, at
//   most log2(DEPTH)+1, each a RAM read and then a compare, and then a settle
//   step. Add and remove then move M entries behind the changed position one
//   place, each moved entry read and then written through the RAM port pair.
//   Unused codes and index errors go straight to the result; get reads the
//   RAM once; find, a rejected add and a missed remove end after the search;
//   delete moves entries with no search. The worst case is an add or a
//   remove at the front of a nearly full table.
//   s_ready is high only in the idle state, entered once a result is handed over,
//   so a beat is not accepted before the last one is through. While m_ready is
//   low a result waits in the output register; the next beat may be accepted,
//   and its result then holds the sequencer, with s_ready low, until it frees.
//   Reset empties the table and clears both configuration registers; RAM
//   contents are not cleared, the entry count alone marks what is valid.
//   Configuration (descending at 0x0, allow_duplicates at 0x4) must be written by
//   the user over the APB port only while the block is idle; it is not enforced.
module sorted_key_table_core
    import skt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Input channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  in_beat_t           s_data,
    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output out_beat_t          m_data,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_SRCH_ADDR = 9'b000000010,
        S_SRCH_CMP  = 9'b000000100,
        S_INS_RD    = 9'b000001000,
        S_INS_WR    = 9'b000010000,
        S_DEL_RD    = 9'b000100000,
        S_DEL_WR    = 9'b001000000,
        S_GET_WAIT  = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    action_t          op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic [PAY_W-1:0] probe_pay_reg, probe_pay_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    status_t          res_status_reg, res_status_next;
    logic [KEY_W-1:0] res_key_reg, res_key_next;
    logic [PAY_W-1:0] res_pay_reg, res_pay_next;
    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_data_reg, m_data_next;
    logic             desc_reg, desc_next;
    logic             dup_reg, dup_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    search_cmd_t  srch_cmd;
    search_stat_t srch_stat;
    logic         pos_in_range;
    logic         s_beat;

    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    skt_search_unit u_search (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (srch_cmd),
        .key        (key_reg),
        .descending (desc_reg),
        .count      (count_reg),
        .probe_key  (ram_rdata[ENTRY_W-1:PAY_W]),
        .stat       (srch_stat)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign s_beat  = s_valid && s_ready;
    assign pos_in_range = CMP_W'(s_data.position) < CMP_W'(count_reg);

    // Configuration writes, decoded on the word address bit.
    always_comb begin
        desc_next = desc_reg;
        dup_next  = dup_reg;
        if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_DESCENDING: desc_next = pwdata[0];
                REG_ALLOW_DUP:  dup_next  = pwdata[0];
                default:        desc_next = desc_reg;
            endcase
        end
    end

    // Configuration reads.
    always_comb begin
        unique case (paddr[2])
            REG_DESCENDING: prdata = PDATA_W'(desc_reg);
            REG_ALLOW_DUP:  prdata = PDATA_W'(dup_reg);
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        probe_pay_next  = probe_pay_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        srch_cmd        = '0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[IDX_W-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = srch_stat.mid;

        unique case (state_reg)
            S_IDLE: begin
                ram_raddr = IDX_W'(s_data.position);
                if (s_beat) begin
                    op_next         = action_t'(s_data.action);
                    key_next        = s_data.key;
                    pay_next        = s_data.payload;
                    res_status_next = STAT_OK;
                    res_key_next    = '0;
                    res_pay_next    = '0;
                    state_next      = S_DONE;
                    unique case (s_data.action) inside
                        ACT_ADD, ACT_REMOVE, ACT_FIND: begin
                            srch_cmd.start = 1'b1;
                            state_next     = S_SRCH_ADDR;
                        end
                        ACT_GET: begin
                            if (pos_in_range) begin
                                state_next = S_GET_WAIT;
                            end else begin
                                res_status_next = STAT_RANGE;
                            end
                        end
                        ACT_DELETE: begin
                            if (pos_in_range) begin
                                idx_next   = CNT_W'(s_data.position);
                                state_next = S_DEL_RD;
                            end else begin
                                res_status_next = STAT_RANGE;
                            end
                        end
                        default: begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end

            // Issue the probe read, or settle the action once the search ends.
            S_SRCH_ADDR: begin
                if (srch_stat.open) begin
                    state_next = S_SRCH_CMP;
                end else begin
                    state_next = S_DONE;
                    unique case (op_reg)
                        ACT_ADD: begin
                            if (srch_stat.hit && !dup_reg) begin
                                res_status_next = STAT_DUPLICATE;
                            end else if (count_reg == CNT_W'(DEPTH)) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        ACT_REMOVE: begin
                            if (srch_stat.hit) begin
                                idx_next   = srch_stat.where;
                                state_next = S_DEL_RD;
                            end else begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (srch_stat.hit) begin
                                res_pay_next = probe_pay_reg;
                            end else begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end

            S_SRCH_CMP: begin
                srch_cmd.compare = 1'b1;
                probe_pay_next   = ram_rdata[PAY_W-1:0];
                state_next       = S_SRCH_ADDR;
            end

            // Open a gap by moving entries up, from the end toward the slot.
            S_INS_RD: begin
                if (idx_reg > srch_stat.where) begin
                    ram_raddr  = IDX_W'(idx_reg - CNT_W'(1));
                    state_next = S_INS_WR;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = IDX_W'(srch_stat.where);
                    ram_wdata  = {key_reg, pay_reg};
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_INS_WR: begin
                ram_we     = 1'b1;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = S_INS_RD;
            end

            // Close the gap by moving entries down, from the slot to the end.
            S_DEL_RD: begin
                if ((idx_reg + CNT_W'(1)) < count_reg) begin
                    ram_raddr  = IDX_W'(idx_reg + CNT_W'(1));
                    state_next = S_DEL_WR;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DEL_WR: begin
                ram_we     = 1'b1;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_DEL_RD;
            end

            S_GET_WAIT: begin
                res_key_next = ram_rdata[ENTRY_W-1:PAY_W];
                res_pay_next = ram_rdata[PAY_W-1:0];
                state_next   = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.status      = res_status_reg;
                    m_data_next.key_out     = res_key_reg;
                    m_data_next.payload_out = res_pay_reg;
                    m_data_next.count       = OCNT_W'(count_reg);
                    m_valid_next            = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            desc_reg    <= 1'b0;
            dup_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            desc_reg    <= desc_next;
            dup_reg     <= dup_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        probe_pay_reg  <= probe_pay_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for sorted_key_table_core: directed and random table actions,
// predicted in SystemVerilog and checked beat by beat on the result channel.
// Depends on skt_pkg and the sorted_key_table_core RTL.
`timescale 1ns / 1ps

module testbench;
    import skt_pkg::*;

    // Action codes the block does not define; they must change nothing.
    localparam logic [ACT_W-1:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_LAST  = 3'd7;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 2 * DEPTH + 2 * IDX_W + 16;
    localparam int POOL_SIZE  = 24;
    localparam int LONG_HOLD  = 400;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_beat_t         s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_beat_t        m_data;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic             pready;

    // Shadow copy of the table and its registers.
    logic [KEY_W-1:0] tbl_key [DEPTH];
    logic [PAY_W-1:0] tbl_pay [DEPTH];
    int               tbl_count = 0;
    logic             cfg_descending = 1'b0;
    logic             cfg_allow_dup = 1'b0;

    in_beat_t         pending_ops[$];
    out_beat_t        predicted_results[$];
    out_beat_t        want_beat;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int err_count = 0;
    int issued_cnt = 0;
    int results_seen = 0;
    int settings_seen = 0;
    int status_hits [8];
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_run = 0;
    int rx_wait = 0;
    bit long_hold_done = 1'b0;

    sorted_key_table_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Binary search exactly as the table does it: stop at the first equal probe,
    // otherwise report the final low bound as the insertion point.
    function automatic bit locate_key(input logic [KEY_W-1:0] k, output int where);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (k == tbl_key[mid]) begin
                where = mid;
                return 1'b1;
            end
            if ((k < tbl_key[mid]) != cfg_descending)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        where = lo;
        return 1'b0;
    endfunction

    // Remove one entry and close the gap behind it.
    function automatic void drop_entry(input int idx);
        int i;
        tbl_count--;
        for (i = idx; i < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_pay[i] = tbl_pay[i + 1];
        end
    endfunction

    // Apply one action to the shadow table and return the result beat it gives.
    function automatic out_beat_t apply_table_op(input in_beat_t op);
        out_beat_t res;
        int where;
        int i;
        bit hit;
        res = '0;
        res.status = STAT_OK;
        case (op.action)
            ACT_ADD: begin
                hit = locate_key(op.key, where);
                if (hit && !cfg_allow_dup) begin
                    res.status = STAT_DUPLICATE;
                end else if (tbl_count >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    for (i = tbl_count; i > where; i--) begin
                        tbl_key[i] = tbl_key[i - 1];
                        tbl_pay[i] = tbl_pay[i - 1];
                    end
                    tbl_key[where] = op.key;
                    tbl_pay[where] = op.payload;
                    tbl_count++;
                end
            end
            ACT_REMOVE: begin
                if (locate_key(op.key, where))
                    drop_entry(where);
                else
                    res.status = STAT_NOT_FOUND;
            end
            ACT_FIND: begin
                if (locate_key(op.key, where))
                    res.payload_out = tbl_pay[where];
                else
                    res.status = STAT_NOT_FOUND;
            end
            ACT_GET: begin
                if (int'(op.position) < tbl_count) begin
                    res.key_out     = tbl_key[op.position];
                    res.payload_out = tbl_pay[op.position];
                end else begin
                    res.status = STAT_RANGE;
                end
            end
            ACT_DELETE: begin
                if (int'(op.position) < tbl_count)
                    drop_entry(int'(op.position));
                else
                    res.status = STAT_RANGE;
            end
            default: begin
            end
        endcase
        res.count = OCNT_W'(tbl_count);
        return res;
    endfunction

    function automatic in_beat_t make_op(input logic [ACT_W-1:0] act,
                                         input logic [KEY_W-1:0] k,
                                         input logic [PAY_W-1:0] pay,
                                         input logic [POS_W-1:0] pos);
        in_beat_t op;
        op.action   = act;
        op.key      = k;
        op.payload  = pay;
        op.position = pos;
        return op;
    endfunction

    // Keys mostly come from a small pool so that finds, removes and duplicates hit.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r == 5)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)] + 64'd1;
        if (r == 6)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)] - 64'd1;
        return {$urandom, $urandom};
    endfunction

    function automatic in_beat_t random_op(input int add_pct);
        logic [ACT_W-1:0] act;
        logic [POS_W-1:0] pos;
        int r;
        if ($urandom_range(0, 99) < add_pct) begin
            act = ACT_ADD;
        end else begin
            r = $urandom_range(0, 19);
            if (r < 5)
                act = ACT_REMOVE;
            else if (r < 10)
                act = ACT_FIND;
            else if (r < 15)
                act = ACT_GET;
            else if (r < 19)
                act = ACT_DELETE;
            else
                act = ACT_W'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
        end
        if ($urandom_range(0, 1) == 0)
            pos = POS_W'($urandom_range(0, 7));
        else
            pos = POS_W'($urandom);
        return make_op(act, pick_key(), $urandom, pos);
    endfunction

    function automatic void queue_op(input in_beat_t op);
        pending_ops.push_back(op);
        issued_cnt++;
    endfunction

    // Wait until every queued beat has come back as a result.
    task automatic wait_quiet();
        while (results_seen != issued_cnt)
            @(negedge aclk);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DESCENDING)
            cfg_descending = data[0];
        else
            cfg_allow_dup = data[0];
    endtask

    // Set both registers (upper bits random, only bit 0 counts), then run a batch.
    task automatic run_phase(input logic desc, input logic dup, input int n,
                             input int add_pct, input bit empty_first);
        int i;
        wait_quiet();
        write_reg(REG_DESCENDING, ($urandom & 32'hFFFF_FFFE) | PDATA_W'(desc));
        write_reg(REG_ALLOW_DUP, ($urandom & 32'hFFFF_FFFE) | PDATA_W'(dup));
        settings_seen++;
        if (empty_first) begin
            for (i = 0; i <= DEPTH; i++)
                queue_op(make_op(ACT_DELETE, {$urandom, $urandom}, $urandom, '0));
        end
        for (i = 0; i < n; i++)
            queue_op(random_op(add_pct));
        wait_quiet();
    endtask

    // Input driver: bursts of beats separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predicted_results.push_back(apply_table_op(s_data));
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    s_data  <= pending_ops.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= ($urandom_range(0, 7) == 0) ?
                                      $urandom_range(40, 150) : $urandom_range(1, 12);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left <= 0;
                            8:          gap_left <= $urandom_range(5, 30);
                            default:    gap_left <= $urandom_range(1, 4);
                        endcase
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: its own stall pattern, plus one long hold that backs up the input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= 1'b0;
        end else if (rx_run > 0) begin
            rx_run  <= rx_run - 1;
            m_ready <= 1'b1;
        end else if (!long_hold_done && results_seen >= 300) begin
            long_hold_done <= 1'b1;
            rx_wait        <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else begin
            m_ready <= 1'b0;
            case ($urandom_range(0, 9))
                6, 7: begin
                    rx_run  <= $urandom_range(20, 120);
                    rx_wait <= 0;
                end
                8: begin
                    rx_run  <= $urandom_range(1, 4);
                    rx_wait <= $urandom_range(10, 40);
                end
                9: begin
                    rx_run  <= 1;
                    rx_wait <= 1;
                end
                default: begin
                    rx_run  <= $urandom_range(1, 8);
                    rx_wait <= $urandom_range(0, 3);
                end
            endcase
        end
    end

    // Result monitor: compare each beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            status_hits[m_data.status]++;
            if (predicted_results.size() == 0) begin
                $error("result beat arrived with no prediction pending");
                err_count++;
            end else begin
                want_beat = predicted_results.pop_front();
                if (m_data.status !== want_beat.status) begin
                    $error("status: expected %0d, got %0d", want_beat.status, m_data.status);
                    err_count++;
                end
                if (m_data.key_out !== want_beat.key_out) begin
                    $error("key_out: expected %h, got %h", want_beat.key_out, m_data.key_out);
                    err_count++;
                end
                if (m_data.payload_out !== want_beat.payload_out) begin
                    $error("payload_out: expected %h, got %h",
                           want_beat.payload_out, m_data.payload_out);
                    err_count++;
                end
                if (m_data.count !== want_beat.count) begin
                    $error("count: expected %0d, got %0d", want_beat.count, m_data.count);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too long without any beat or register access means a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int i;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        key_pool[3] = 64'd1;
        key_pool[4] = ~64'd1;
        for (i = 5; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        for (i = 0; i < 8; i++)
            status_hits[i] = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-table errors, extremes, duplicates, ranges, unused codes.
        write_reg(REG_DESCENDING, '0);
        write_reg(REG_ALLOW_DUP, '0);
        settings_seen++;
        queue_op(make_op(ACT_GET, '0, '0, '0));
        queue_op(make_op(ACT_DELETE, '0, '0, '1));
        queue_op(make_op(ACT_FIND, '0, '0, '0));
        queue_op(make_op(ACT_REMOVE, '1, '0, '0));
        queue_op(make_op(ACT_ADD, '0, '0, '0));
        queue_op(make_op(ACT_ADD, '1, '1, '1));
        queue_op(make_op(ACT_ADD, 64'h8000_0000_0000_0000, 32'hA5A5_A5A5, '0));
        queue_op(make_op(ACT_ADD, '0, 32'd1, '0));
        queue_op(make_op(ACT_ADD, 64'd1, 32'h5555_5555, '0));
        queue_op(make_op(ACT_FIND, '1, '0, '0));
        queue_op(make_op(ACT_FIND, 64'd2, '0, '0));
        queue_op(make_op(ACT_GET, '0, '0, POS_W'(0)));
        queue_op(make_op(ACT_GET, '0, '0, POS_W'(3)));
        queue_op(make_op(ACT_GET, '0, '0, POS_W'(4)));
        queue_op(make_op(ACT_GET, '1, '1, '1));
        queue_op(make_op(ACT_REMOVE, 64'h8000_0000_0000_0000, '0, '0));
        queue_op(make_op(ACT_DELETE, '0, '0, POS_W'(0)));
        for (i = int'(ACT_RSVD_FIRST); i <= int'(ACT_RSVD_LAST); i++)
            queue_op(make_op(ACT_W'(i), '1, '1, '1));
        queue_op(make_op(ACT_FIND, 64'd1, '0, '0));
        queue_op(make_op(ACT_DELETE, '0, '0, POS_W'(1)));
        queue_op(make_op(ACT_REMOVE, 64'd1, '0, '0));
        queue_op(make_op(ACT_FIND, '1, '0, '0));
        wait_quiet();

        // Random phases over all register settings; some switch order on a live table.
        run_phase(1'b0, 1'b0, 180, 45, 1'b0);
        run_phase(1'b0, 1'b1, 220, 62, 1'b0);
        run_phase(1'b1, 1'b0, 170, 50, 1'b1);
        run_phase(1'b1, 1'b1, 220, 65, 1'b0);
        run_phase(1'b0, 1'b1, 80, 40, 1'b0);
        run_phase(1'b0, 1'b0, 80, 45, 1'b1);

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (predicted_results.size() != 0) begin
            $error("%0d predicted results never arrived", predicted_results.size());
            err_count++;
        end

        $display("Ran %0d beats over %0d register settings, %0d results checked.",
                 issued_cnt, settings_seen, results_seen);
        $display("Outcomes: %0d full, %0d duplicate, %0d not found, %0d out of range.",
                 status_hits[STAT_FULL], status_hits[STAT_DUPLICATE],
                 status_hits[STAT_NOT_FOUND], status_hits[STAT_RANGE]);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
